// ===== rtl/sps_pkg.sv =====
// Shared types and constants for the snapshot stream parser.
`timescale 1ns / 1ps

package sps_pkg;

    typedef enum logic [2:0] {
        KIND_COUNT   = 3'd0,
        KIND_INDEX   = 3'd1,
        KIND_GEN     = 3'd2,
        KIND_MASK    = 3'd3,
        KIND_LEN     = 3'd4,
        KIND_PAYLOAD = 3'd5,
        KIND_DONE    = 3'd6,
        KIND_ERROR   = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_INDEX = 3'd1,
        PH_GEN   = 3'd2,
        PH_MASK  = 3'd3,
        PH_LEN   = 3'd4,
        PH_PAY   = 3'd5,
        PH_DONE  = 3'd6,
        PH_ERR   = 3'd7
    } phase_t;

    localparam int VALUE_W     = 32;
    localparam int POS_W       = 5;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_LVL_W  = 3;
    localparam int GEN_LAST    = 3;

    typedef struct packed {
        kind_t                kind;
        logic [VALUE_W-1:0]   field_value;
        logic [POS_W-1:0]     byte_position;
        logic                 entity_end;
        logic                 last_of_run;
    } result_t;

    // Up to two results for one input byte, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } dec_out_t;

    typedef struct packed {
        logic                  room_for_two;
        logic [FIFO_LVL_W-1:0] level;
    } fifo_status_t;

endpackage

// ===== rtl/sps_decoder.sv =====
// Parser state and per-byte decode of varints, generation, mask and payload.
`timescale 1ns / 1ps

module sps_decoder #(
    parameter int MASK_BYTES       = 32,
    parameter int VARINT_MAX_BYTES = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output sps_pkg::dec_out_t dec_out
);
    import sps_pkg::*;

    phase_t               phase_reg, phase_next, phase_step;
    logic [VALUE_W-1:0]   varint_accum_reg, varint_accum_next;
    logic [2:0]           varint_seen_reg, varint_seen_next;
    logic [VALUE_W-1:0]   entities_left_reg, entities_left_next;
    logic [5:0]           fixed_cnt_reg, fixed_cnt_next;
    logic [23:0]          gen_accum_reg, gen_accum_next;
    logic [VALUE_W-1:0]   payload_left_reg, payload_left_next;

    logic [VALUE_W-1:0]   vi_acc;
    logic [2:0]           vi_seen_inc;
    logic                 vi_done, vi_err;
    logic                 entity_last, pay_last, mask_last;
    logic [6:0]           mask_cnt_inc;
    logic [23:0]          gen_merge;

    logic                 pv, dv, ev;
    result_t              p_res, d_res, e_res;

    // Shared step terms
    always_comb begin
        case (varint_seen_reg)
            3'd0:    vi_acc = varint_accum_reg | {25'd0, data_byte[6:0]};
            3'd1:    vi_acc = varint_accum_reg | {18'd0, data_byte[6:0], 7'd0};
            3'd2:    vi_acc = varint_accum_reg | {11'd0, data_byte[6:0], 14'd0};
            3'd3:    vi_acc = varint_accum_reg | {4'd0, data_byte[6:0], 21'd0};
            3'd4:    vi_acc = varint_accum_reg | {data_byte[3:0], 28'd0};
            default: vi_acc = varint_accum_reg;
        endcase
        vi_seen_inc  = varint_seen_reg + 3'd1;
        vi_done      = !data_byte[7];
        vi_err       = data_byte[7] && (vi_seen_inc >= 3'(VARINT_MAX_BYTES));
        entity_last  = (entities_left_reg == 32'd1);
        pay_last     = (payload_left_reg == 32'd1);
        mask_cnt_inc = {1'b0, fixed_cnt_reg} + 7'd1;
        mask_last    = (mask_cnt_inc >= 7'(MASK_BYTES));
        case (fixed_cnt_reg[1:0])
            2'd0:    gen_merge = gen_accum_reg | {16'd0, data_byte};
            2'd1:    gen_merge = gen_accum_reg | {8'd0, data_byte, 8'd0};
            default: gen_merge = gen_accum_reg | {data_byte, 16'd0};
        endcase
    end

    // Next state
    always_comb begin
        phase_step         = phase_reg;
        varint_accum_next  = varint_accum_reg;
        varint_seen_next   = varint_seen_reg;
        entities_left_next = entities_left_reg;
        fixed_cnt_next     = fixed_cnt_reg;
        gen_accum_next     = gen_accum_reg;
        payload_left_next  = payload_left_reg;
        if (item_valid) begin
            unique case (phase_reg)
                PH_COUNT, PH_INDEX, PH_LEN: begin
                    if (vi_err) begin
                        phase_step = PH_ERR;
                    end else if (vi_done) begin
                        varint_accum_next = '0;
                        varint_seen_next  = '0;
                        if (phase_reg == PH_COUNT) begin
                            entities_left_next = vi_acc;
                            phase_step = (vi_acc == 32'd0) ? PH_DONE : PH_INDEX;
                        end else if (phase_reg == PH_INDEX) begin
                            fixed_cnt_next = '0;
                            gen_accum_next = '0;
                            phase_step     = PH_GEN;
                        end else begin
                            payload_left_next = vi_acc;
                            if (vi_acc == 32'd0) begin
                                entities_left_next = entities_left_reg - 32'd1;
                                phase_step = entity_last ? PH_DONE : PH_INDEX;
                            end else begin
                                phase_step = PH_PAY;
                            end
                        end
                    end else begin
                        varint_accum_next = vi_acc;
                        varint_seen_next  = vi_seen_inc;
                    end
                end
                PH_GEN: begin
                    if (fixed_cnt_reg >= 6'(GEN_LAST)) begin
                        fixed_cnt_next = '0;
                        gen_accum_next = '0;
                        phase_step     = PH_MASK;
                    end else begin
                        gen_accum_next = gen_merge;
                        fixed_cnt_next = fixed_cnt_reg + 6'd1;
                    end
                end
                PH_MASK: begin
                    if (mask_last) begin
                        fixed_cnt_next = '0;
                        phase_step     = PH_LEN;
                    end else begin
                        fixed_cnt_next = mask_cnt_inc[5:0];
                    end
                end
                PH_PAY: begin
                    payload_left_next = payload_left_reg - 32'd1;
                    if (pay_last) begin
                        entities_left_next = entities_left_reg - 32'd1;
                        phase_step = entity_last ? PH_DONE : PH_INDEX;
                    end
                end
                PH_DONE, PH_ERR: begin
                end
                default: begin
                end
            endcase
        end
        phase_next = phase_step;
        // End of buffer: back to the reset state for the next one
        if (item_valid && last_byte) begin
            phase_next         = PH_COUNT;
            varint_accum_next  = '0;
            varint_seen_next   = '0;
            entities_left_next = '0;
            fixed_cnt_next     = '0;
            gen_accum_next     = '0;
            payload_left_next  = '0;
        end
    end

    // Results
    always_comb begin
        pv    = 1'b0;
        dv    = 1'b0;
        p_res = '{kind: KIND_ERROR, field_value: '0, byte_position: '0,
                  entity_end: 1'b0, last_of_run: 1'b0};
        d_res = '{kind: KIND_DONE, field_value: '0, byte_position: '0,
                  entity_end: 1'b0, last_of_run: 1'b0};
        e_res = '{kind: KIND_ERROR, field_value: '0, byte_position: '0,
                  entity_end: 1'b0, last_of_run: 1'b0};
        if (item_valid) begin
            unique case (phase_reg)
                PH_COUNT, PH_INDEX, PH_LEN: begin
                    if (vi_err) begin
                        pv = 1'b1;
                    end else if (vi_done) begin
                        pv = 1'b1;
                        p_res.field_value = vi_acc;
                        if (phase_reg == PH_COUNT) begin
                            p_res.kind = KIND_COUNT;
                            dv = (vi_acc == 32'd0);
                        end else if (phase_reg == PH_INDEX) begin
                            p_res.kind = KIND_INDEX;
                        end else begin
                            p_res.kind       = KIND_LEN;
                            p_res.entity_end = (vi_acc == 32'd0);
                            dv = (vi_acc == 32'd0) && entity_last;
                        end
                    end
                end
                PH_GEN: begin
                    if (fixed_cnt_reg >= 6'(GEN_LAST)) begin
                        pv = 1'b1;
                        p_res.kind        = KIND_GEN;
                        p_res.field_value = {data_byte, gen_accum_reg};
                    end
                end
                PH_MASK: begin
                    pv = 1'b1;
                    p_res.kind          = KIND_MASK;
                    p_res.field_value   = {24'd0, data_byte};
                    p_res.byte_position = fixed_cnt_reg[POS_W-1:0];
                end
                PH_PAY: begin
                    pv = 1'b1;
                    p_res.kind        = KIND_PAYLOAD;
                    p_res.field_value = {24'd0, data_byte};
                    p_res.entity_end  = pay_last;
                    dv = pay_last && entity_last;
                end
                PH_DONE, PH_ERR: begin
                end
                default: begin
                end
            endcase
        end
        // Truncated buffer
        ev = item_valid && last_byte && (phase_step != PH_DONE) && (phase_step != PH_ERR);

        dec_out.count  = {1'b0, pv} + {1'b0, dv} + {1'b0, ev};
        dec_out.first  = pv ? p_res : e_res;
        dec_out.second = dv ? d_res : e_res;
        dec_out.first.last_of_run  = (dec_out.count == 2'd1);
        dec_out.second.last_of_run = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_COUNT;
            varint_accum_reg  <= '0;
            varint_seen_reg   <= '0;
            entities_left_reg <= '0;
            fixed_cnt_reg     <= '0;
            gen_accum_reg     <= '0;
            payload_left_reg  <= '0;
        end else begin
            phase_reg         <= phase_next;
            varint_accum_reg  <= varint_accum_next;
            varint_seen_reg   <= varint_seen_next;
            entities_left_reg <= entities_left_next;
            fixed_cnt_reg     <= fixed_cnt_next;
            gen_accum_reg     <= gen_accum_next;
            payload_left_reg  <= payload_left_next;
        end
    end

endmodule

// ===== rtl/sps_result_fifo.sv =====
// Four-entry result queue, up to two writes and one read per cycle.
`timescale 1ns / 1ps

module sps_result_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sps_pkg::dec_out_t     wr_data,
    input  logic                  rd_en,
    output logic                  rd_valid,
    output sps_pkg::result_t      rd_data,
    output sps_pkg::fifo_status_t status
);
    import sps_pkg::*;

    result_t                entries [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LVL_W-1:0]  level_reg, level_next;
    logic                   pop;

    assign rd_valid = (level_reg != '0);
    assign rd_data  = entries[rd_ptr_reg];
    assign pop      = rd_en && rd_valid;

    assign status.room_for_two = (level_reg <= FIFO_LVL_W'(FIFO_DEPTH - 2));
    assign status.level        = level_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(wr_data.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        level_next  = level_reg + FIFO_LVL_W'(wr_data.count) - FIFO_LVL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (wr_data.count != 2'd0) begin
            entries[wr_ptr_reg] <= wr_data.first;
        end
        if (wr_data.count == 2'd2) begin
            entries[wr_ptr_reg + FIFO_PTR_W'(1)] <= wr_data.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ===== rtl/snapshot_stream_parser_top.sv =====
// Top level of the snapshot stream parser: input register, decoder, result queue.
`timescale 1ns / 1ps

// Parses a snapshot buffer, one byte per item on the s_ side (s_tlast on the
// final byte), into decoded results on the m_ side: entity count, and per
// entity index, generation, each mask byte, payload length and each payload
// byte, then done; error on an overlong varint or a truncated buffer, after
// which the rest of that buffer is dropped (earlier results of a truncated
// buffer are to be discarded downstream). While the queue has room for two
// results a byte is taken every cycle; a byte that yields two results (zero
// count, last entity's end, truncation after a result) uses the single output
// port twice, absorbed by a four-entry result queue, so sustained input is
// one byte per output result. Input register and queue precede a byte's first
// result. m_tlast marks the final result caused by one input byte.

module snapshot_stream_parser_top #(
    parameter int MASK_BYTES       = 32,
    parameter int VARINT_MAX_BYTES = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] field_value, [36:32] byte_position,
                                   // [37] entity_end, [39:38] zero
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // last_of_run
);
    import sps_pkg::*;

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;
    logic          s_accept, consume;
    dec_out_t      dec_out;
    result_t       head;
    fifo_status_t  fifo_status;

    assign consume  = in_valid_reg && fifo_status.room_for_two;
    assign s_tready = !in_valid_reg || consume;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    sps_decoder #(
        .MASK_BYTES       (MASK_BYTES),
        .VARINT_MAX_BYTES (VARINT_MAX_BYTES)
    ) u_decoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (consume),
        .data_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .dec_out    (dec_out)
    );

    sps_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_data  (dec_out),
        .rd_en    (m_tready),
        .rd_valid (m_tvalid),
        .rd_data  (head),
        .status   (fifo_status)
    );

    assign m_tdata = {2'b00, head.entity_end, head.byte_position, head.field_value};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

    // Done and error always close the run of their byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_DONE || m_tuser == KIND_ERROR)) |-> m_tlast)
        else $error("done or error result without tlast");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_status.level <= FIFO_LVL_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (dec_out.count != 2'd0) |-> consume)
        else $error("decoder produced results without a consumed byte");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule
